FILE: sv/olst_pkg.sv
// Shared types and codes for the ordered list store.
// Used by olst_cell and ordered_list_store; depends on nothing else.

package olst_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int WORD_W           = 32;
  localparam int CMD_W            = 3;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 5;
  localparam int IN_TDATA_W       = 40;
  localparam int OUT_TDATA_W      = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_POP_FRONT    = 3'd1,
    CMD_REMOVE_VALUE = 3'd2,
    CMD_POP_BACK     = 3'd3,
    CMD_LIST         = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // what every cell does this cycle
  typedef struct packed {
    logic load;    // take the left neighbour (push at the front)
    logic rotate;  // take the right neighbour, tail takes the head
    logic drop;    // take the right neighbour, head word leaves the list
  } cell_op_t;

endpackage

FILE: sv/olst_cell.sv
// One storage cell of the ordered list store chain.
// Depends on olst_pkg for the cell operation struct.

module olst_cell
  import olst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int IDX      = 0,
  localparam int UW      = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [UW-1:0]     used,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  input  logic [WORD_W-1:0] head_word,
  output logic [WORD_W-1:0] word
);

  localparam logic [UW-1:0] IDX_PLUS1 = UW'(IDX + 1);

  logic tail;

  assign tail = (used == IDX_PLUS1);

  always_ff @(posedge clk) begin
    if (op.load) begin
      word <= left_word;
    end else if (op.rotate) begin
      word <= tail ? head_word : right_word;
    end else if (op.drop) begin
      word <= right_word;
    end
  end

endmodule

FILE: sv/ordered_list_store.sv
// Top level of the ordered list store: command sequencer, output register, cell chain.
// Depends on olst_pkg and olst_cell.

// Ordered store of up to CAPACITY signed 32-bit words held in a chain of cells, front in
// cell 0. Remove front, remove last, remove by value and list each walk the whole list
// once by rotating the chain one place per cycle while the output register can take a beat,
// and look only at the head cell; a removal drops the word as it passes the head.
// Rejected or empty-list commands and unused command codes need no walk, like a push;
// their beat is valid the cycle after the accept. One command is worked on at a time; the
// next is taken once the walk ends and the output register is free or being drained.

module ordered_list_store
  import olst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int UW      = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] cmd, [34:3] value, [39:35] zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [33:2] value_res, [38:34] count
  output logic                   m_tlast
);

  localparam logic [UW-1:0] CAP_U = UW'(CAPACITY);

  state_t                state, state_next;
  cmd_t                  cmd_q, cmd_q_next;
  logic [WORD_W-1:0]     val_q, val_q_next;
  logic [UW-1:0]         used, used_next;
  logic [UW-1:0]         pos, pos_next;
  logic [UW-1:0]         n, n_next;
  logic                  found, found_next;
  logic [WORD_W-1:0]     found_val, found_val_next;

  logic                  out_valid, out_valid_next;
  status_t               out_status, out_status_next;
  logic [WORD_W-1:0]     out_val, out_val_next;
  logic                  out_last, out_last_next;
  logic [COUNT_W-1:0]    out_count, out_count_next;

  cell_op_t              op;
  logic [WORD_W-1:0]     cell_word [CAPACITY];
  logic [WORD_W-1:0]     head;

  cmd_t                  in_cmd;
  logic [WORD_W-1:0]     in_value;
  logic                  out_free;
  logic                  last_step;
  logic                  hit;
  logic                  step_ok;
  logic                  emit;
  logic [UW-1:0]         cnt_src;
  logic [UW+COUNT_W-1:0] cnt_ext;

  assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
  assign in_value = s_tdata[CMD_W+WORD_W-1:CMD_W];
  assign head     = cell_word[0];
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W-STATUS_W-WORD_W-COUNT_W){1'b0}}, out_count, out_val,
                     out_status};

  assign last_step = ((pos + UW'(1)) == n);
  assign hit = !found &&
               (((cmd_q == CMD_REMOVE_VALUE) && (head == val_q)) ||
                ((cmd_q == CMD_POP_FRONT) && (pos == '0)) ||
                ((cmd_q == CMD_POP_BACK) && last_step));
  assign step_ok = (cmd_q == CMD_LIST) ? out_free : (!last_step || out_free);

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_src};

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    val_q_next      = val_q;
    used_next       = used;
    pos_next        = pos;
    n_next          = n;
    found_next      = found;
    found_val_next  = found_val;
    op              = '0;
    emit            = 1'b0;
    out_status_next = out_status;
    out_val_next    = out_val;
    out_last_next   = out_last;
    cnt_src         = used;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd_q_next = in_cmd;
          val_q_next = in_value;
          unique case (in_cmd)
            CMD_PUSH_FRONT: begin
              emit          = 1'b1;
              out_val_next  = '0;
              out_last_next = 1'b1;
              if (used == CAP_U) begin
                out_status_next = ST_FULL;
              end else begin
                op.load         = 1'b1;
                used_next       = used + UW'(1);
                cnt_src         = used + UW'(1);
                out_status_next = ST_OK;
              end
            end
            CMD_POP_FRONT, CMD_REMOVE_VALUE, CMD_POP_BACK, CMD_LIST: begin
              if (used == '0) begin
                emit            = 1'b1;
                out_status_next = ST_EMPTY;
                out_val_next    = '0;
                out_last_next   = 1'b1;
              end else begin
                state_next = S_SCAN;
                pos_next   = '0;
                n_next     = used;
                found_next = 1'b0;
              end
            end
            default: begin
              emit            = 1'b1;
              out_status_next = ST_OK;
              out_val_next    = '0;
              out_last_next   = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (step_ok) begin
          pos_next = pos + UW'(1);
          if (hit) begin
            op.drop        = 1'b1;
            used_next      = used - UW'(1);
            found_next     = 1'b1;
            found_val_next = head;
          end else begin
            op.rotate = 1'b1;
          end
          if (cmd_q == CMD_LIST) begin
            emit            = 1'b1;
            out_status_next = ST_OK;
            out_val_next    = head;
            out_last_next   = last_step;
          end else if (last_step) begin
            emit          = 1'b1;
            out_last_next = 1'b1;
            if (hit) begin
              out_status_next = ST_OK;
              out_val_next    = head;
              cnt_src         = used - UW'(1);
            end else if (found) begin
              out_status_next = ST_OK;
              out_val_next    = found_val;
            end else begin
              out_status_next = ST_NOTFOUND;
              out_val_next    = '0;
            end
          end
          if (last_step) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_count_next = emit ? cnt_ext[COUNT_W-1:0] : out_count;
    out_valid_next = emit ? 1'b1 : (out_valid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      out_valid <= out_valid_next;
      found     <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    val_q      <= val_q_next;
    pos        <= pos_next;
    n          <= n_next;
    found_val  <= found_val_next;
    out_status <= out_status_next;
    out_val    <= out_val_next;
    out_last   <= out_last_next;
    out_count  <= out_count_next;
  end

  // cell chain: left input of the front cell is the pushed word, the end cell wraps to the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olst_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .used       (used),
      .left_word  ((i == 0) ? in_value : cell_word[(i == 0) ? 0 : i - 1]),
      .right_word (cell_word[(i == CAPACITY - 1) ? 0 : i + 1]),
      .head_word  (head),
      .word       (cell_word[i])
    );
  end

endmodule
